### sv/agfl_pkg.sv
// ----------------------------------------------------------------------------
// agfl_pkg
// Shared widths, register indexes and pipeline types for the affinity
// graph block.
// ----------------------------------------------------------------------------
package agfl_pkg;

    localparam int LABEL_W = 32;
    localparam int SIZE_W  = 11;
    localparam int DIST_W  = 10;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 3;

    // Largest extent an 11-bit size register can hold
    localparam int SIZE_MAX = 2047;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_SIZE_X = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SIZE_Y = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SIZE_Z = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DIST_X = 3'd3;
    localparam logic [CIDX_W-1:0] REG_DIST_Y = 3'd4;
    localparam logic [CIDX_W-1:0] REG_DIST_Z = 3'd5;

    // Per-voxel side information carried alongside the history read
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [2:0]         gate;      // positive, in range, offset fits
        logic [2:0]         self_cmp;  // zero distance: no compare needed
        logic               last;
        logic               short_z;
    } agfl_s1_t;

endpackage

### sv/affinity_graph_from_labels.sv
// ----------------------------------------------------------------------------
// affinity_graph_from_labels
// Streams one label per voxel in raster order and returns x, y and z
// affinity bits per voxel from a ring store of past labels.
// ----------------------------------------------------------------------------
// One voxel is taken per clock cycle, sustained while the output is not
// stalled; its result goes through the history read, then the output
// register. The rate is set by the label history: two copies of the ring
// store are written in parallel, one giving the x and y neighbour reads and
// the other the z neighbour read, all at fixed offsets behind the write
// pointer. After any configuration write the input is held off while the y
// and z offsets (dist_y*size_x and dist_z*size_y*size_x) are recomputed
// through registered multipliers. The history store has no clearing pass:
// every entry read in a well-formed volume was written earlier in that volume.
// ----------------------------------------------------------------------------
module affinity_graph_from_labels
    import agfl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536,
    parameter int MAX_EXTENT    = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CIDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [LABEL_W-1:0] s_label,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_aff_x,
    output logic                      m_aff_y,
    output logic                      m_aff_z,
    output logic                      m_volume_end,
    output logic                      m_history_short
);

    localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
    localparam int EXT_MAX = (MAX_EXTENT < SIZE_MAX) ? MAX_EXTENT : SIZE_MAX;
    localparam int POS_W   = $clog2(EXT_MAX);
    localparam logic [ADDR_W:0]  DEPTH_C = (ADDR_W+1)'(HISTORY_DEPTH);
    localparam logic [31:0]      DEPTH_W = 32'(HISTORY_DEPTH);
    localparam logic [SIZE_W-1:0] EXT_C  = SIZE_W'(EXT_MAX);
    localparam logic [1:0]       SETTLE  = 2'd3;

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [DIST_W-1:0] dist_x_reg, dist_y_reg, dist_z_reg;
    logic [1:0]        settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_W'(1);
            size_y_reg <= SIZE_W'(1);
            size_z_reg <= SIZE_W'(1);
            dist_x_reg <= DIST_W'(1);
            dist_y_reg <= DIST_W'(1);
            dist_z_reg <= DIST_W'(1);
            settle_reg <= SETTLE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_wdata;
                REG_SIZE_Y: size_y_reg <= cfg_wdata;
                REG_SIZE_Z: size_z_reg <= cfg_wdata;
                REG_DIST_X: dist_x_reg <= cfg_wdata[DIST_W-1:0];
                REG_DIST_Y: dist_y_reg <= cfg_wdata[DIST_W-1:0];
                REG_DIST_Z: dist_z_reg <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
            settle_reg <= SETTLE;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // Clamp extents: zero acts as one, above the limit acts as the limit
    logic [SIZE_W-1:0] sx, sy, sz;
    always_comb begin
        sx = (size_x_reg == '0) ? SIZE_W'(1) : ((size_x_reg > EXT_C) ? EXT_C : size_x_reg);
        sy = (size_y_reg == '0) ? SIZE_W'(1) : ((size_y_reg > EXT_C) ? EXT_C : size_y_reg);
        sz = (size_z_reg == '0) ? SIZE_W'(1) : ((size_z_reg > EXT_C) ? EXT_C : size_z_reg);
    end

    // Derived offsets, recomputed every cycle; valid once settle_reg is zero
    logic [DIST_W+SIZE_W-1:0]   off_y_reg;
    logic [2*SIZE_W-1:0]        plane_reg;
    logic [DIST_W+2*SIZE_W-1:0] off_z_reg;
    logic                       y_fits_reg, z_short_reg;

    always_ff @(posedge aclk) begin
        off_y_reg   <= dist_y_reg * sx;
        plane_reg   <= sy * sx;
        off_z_reg   <= dist_z_reg * plane_reg;
        y_fits_reg  <= 32'(off_y_reg) <= DEPTH_W;
        z_short_reg <= 32'(off_z_reg) > DEPTH_W;
    end

    // ---------------- position and pointer ----------------
    logic [POS_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic              x_wrap, y_wrap, z_wrap;
    logic              s_fire;

    assign x_wrap = (SIZE_W+1)'(pos_x_reg) + 1'b1 >= (SIZE_W+1)'(sx);
    assign y_wrap = (SIZE_W+1)'(pos_y_reg) + 1'b1 >= (SIZE_W+1)'(sy);
    assign z_wrap = (SIZE_W+1)'(pos_z_reg) + 1'b1 >= (SIZE_W+1)'(sz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            wp_reg    <= '0;
        end else if (s_fire) begin
            wp_reg <= (wp_reg == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (x_wrap) begin
                pos_x_reg <= '0;
                if (y_wrap) begin
                    pos_y_reg <= '0;
                    pos_z_reg <= z_wrap ? '0 : pos_z_reg + 1'b1;
                end else begin
                    pos_y_reg <= pos_y_reg + 1'b1;
                end
            end else begin
                pos_x_reg <= pos_x_reg + 1'b1;
            end
        end
    end

    // ---------------- neighbour addresses ----------------
    logic [ADDR_W:0]   diff_x, diff_y, diff_z;
    logic [ADDR_W-1:0] addr_x, addr_y, addr_z;

    always_comb begin
        diff_x = {1'b0, wp_reg} - (ADDR_W+1)'(dist_x_reg);
        diff_y = {1'b0, wp_reg} - (ADDR_W+1)'(off_y_reg);
        diff_z = {1'b0, wp_reg} - (ADDR_W+1)'(off_z_reg);
        // wrap a borrow back into the ring
        addr_x = diff_x[ADDR_W] ? ADDR_W'(diff_x + DEPTH_C) : diff_x[ADDR_W-1:0];
        addr_y = diff_y[ADDR_W] ? ADDR_W'(diff_y + DEPTH_C) : diff_y[ADDR_W-1:0];
        addr_z = diff_z[ADDR_W] ? ADDR_W'(diff_z + DEPTH_C) : diff_z[ADDR_W-1:0];
    end

    // ---------------- label history ----------------
    // Read-first: an offset equal to the depth sees the old entry
    logic [LABEL_W-1:0] hist_xy_mem [HISTORY_DEPTH];
    logic [LABEL_W-1:0] hist_z_mem  [HISTORY_DEPTH];
    logic [LABEL_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hist_xy_mem[wp_reg] <= s_label;
            rd_x_reg            <= hist_xy_mem[addr_x];
            rd_y_reg            <= hist_xy_mem[addr_y];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hist_z_mem[wp_reg] <= s_label;
            rd_z_reg           <= hist_z_mem[addr_z];
        end
    end

    // ---------------- stage 1: side information ----------------
    logic     positive;
    agfl_s1_t s1_next;
    agfl_s1_t s1_reg;
    logic     s1_valid_reg;
    logic     s1_adv;

    assign positive = (s_label > 0);

    always_comb begin
        s1_next.label      = s_label;
        s1_next.gate[0]    = positive && (SIZE_W'(pos_x_reg) >= SIZE_W'(dist_x_reg));
        s1_next.gate[1]    = positive && (SIZE_W'(pos_y_reg) >= SIZE_W'(dist_y_reg))
                             && y_fits_reg;
        s1_next.gate[2]    = positive && (SIZE_W'(pos_z_reg) >= SIZE_W'(dist_z_reg))
                             && !z_short_reg;
        s1_next.self_cmp   = {dist_z_reg == '0, dist_y_reg == '0, dist_x_reg == '0};
        s1_next.last       = x_wrap && y_wrap && z_wrap;
        s1_next.short_z    = z_short_reg;
    end

    assign s1_adv  = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = (settle_reg == 2'd0) && (!s1_valid_reg || s1_adv);
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_reg <= s1_next;
        end
    end

    // ---------------- output register ----------------
    logic [2:0] aff_next;
    logic       m_valid_reg;
    logic [2:0] aff_reg;
    logic       end_reg, short_reg;

    always_comb begin
        aff_next[0] = s1_reg.gate[0] && (s1_reg.self_cmp[0] || rd_x_reg == s1_reg.label);
        aff_next[1] = s1_reg.gate[1] && (s1_reg.self_cmp[1] || rd_y_reg == s1_reg.label);
        aff_next[2] = s1_reg.gate[2] && (s1_reg.self_cmp[2] || rd_z_reg == s1_reg.label);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            aff_reg   <= aff_next;
            end_reg   <= s1_reg.last;
            short_reg <= s1_reg.short_z;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_aff_x         = aff_reg[0];
    assign m_aff_y         = aff_reg[1];
    assign m_aff_z         = aff_reg[2];
    assign m_volume_end    = end_reg;
    assign m_history_short = short_reg;

`ifndef SYNTHESIS
    // A z offset past the store never yields a z affinity
    a_short_no_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_history_short |-> !m_aff_z)
        else $error("z affinity set while history is short");

    // Offsets are stale right after a register write
    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input accepted before offsets settled");

    // An accepted voxel always lands in the read stage
    a_fire_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> s1_valid_reg)
        else $error("accepted voxel lost before read stage");
`endif

endmodule

### verif/affinity_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affinity_tb_pkg
// Result type and affinity tracker for the affinity graph testbench: keeps
// its own label ring, voxel counters and register copies, predicts the three
// affinity bits and the flags for every voxel transfer and checks result
// transfers against them in order.
// ----------------------------------------------------------------------------
package affinity_tb_pkg;

    import agfl_pkg::*;

    localparam int HIST_DEPTH = 65536;
    localparam int EXTENT_MAX = 1024;

    typedef struct packed {
        logic aff_x;
        logic aff_y;
        logic aff_z;
        logic volume_end;
        logic history_short;
    } voxel_affinity_t;

    class AffinityTracker;
        bit [SIZE_W-1:0]  size_reg [3];
        bit [DIST_W-1:0]  dist_reg [3];
        bit [LABEL_W-1:0] label_ring [HIST_DEPTH];
        bit [15:0]        ring_ptr;
        int               voxel_pos [3];
        voxel_affinity_t  expected_affinities [$];
        int               failures;
        int               checked;
        int               ones [3];
        int               short_seen;

        function new();
            for (int a = 0; a < 3; a++) begin
                size_reg[a]  = 1;
                dist_reg[a]  = 1;
                voxel_pos[a] = 0;
                ones[a]      = 0;
            end
            ring_ptr   = 0;
            failures   = 0;
            checked    = 0;
            short_seen = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_SIZE_X: size_reg[0] = value;
                REG_SIZE_Y: size_reg[1] = value;
                REG_SIZE_Z: size_reg[2] = value;
                REG_DIST_X: dist_reg[0] = value[DIST_W-1:0];
                REG_DIST_Y: dist_reg[1] = value[DIST_W-1:0];
                REG_DIST_Z: dist_reg[2] = value[DIST_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_affinities.size();
        endfunction

        function void predict_voxel(logic [LABEL_W-1:0] lab);
            int              ext [3];
            longint          offset [3];
            bit              positive;
            bit              aff [3];
            bit [15:0]       slot;
            voxel_affinity_t want;
            for (int a = 0; a < 3; a++) begin
                if (size_reg[a] == 0)
                    ext[a] = 1;
                else if (size_reg[a] > EXTENT_MAX)
                    ext[a] = EXTENT_MAX;
                else
                    ext[a] = size_reg[a];
            end
            offset[0] = dist_reg[0];
            offset[1] = longint'(dist_reg[1]) * ext[0];
            offset[2] = longint'(dist_reg[2]) * ext[1] * ext[0];
            positive  = (lab != 0) && !lab[LABEL_W-1];
            for (int a = 0; a < 3; a++) begin
                if (!positive || voxel_pos[a] < dist_reg[a] || offset[a] > HIST_DEPTH) begin
                    aff[a] = 1'b0;
                end else if (offset[a] == 0) begin
                    aff[a] = 1'b1;
                end else begin
                    // an offset of the full depth lands on the slot about to be written
                    slot   = ring_ptr - 16'(offset[a]);
                    aff[a] = (label_ring[slot] == lab);
                end
            end
            want.aff_x         = aff[0];
            want.aff_y         = aff[1];
            want.aff_z         = aff[2];
            want.volume_end    = (voxel_pos[0] + 1 >= ext[0]) && (voxel_pos[1] + 1 >= ext[1])
                                 && (voxel_pos[2] + 1 >= ext[2]);
            want.history_short = (offset[2] > HIST_DEPTH);
            expected_affinities = {expected_affinities, want};

            label_ring[ring_ptr] = lab;
            ring_ptr++;
            // advance raster counters, x fastest
            if (voxel_pos[0] + 1 >= ext[0]) begin
                voxel_pos[0] = 0;
                if (voxel_pos[1] + 1 >= ext[1]) begin
                    voxel_pos[1] = 0;
                    if (voxel_pos[2] + 1 >= ext[2])
                        voxel_pos[2] = 0;
                    else
                        voxel_pos[2]++;
                end else begin
                    voxel_pos[1]++;
                end
            end else begin
                voxel_pos[0]++;
            end
        endfunction

        function void compare_result(voxel_affinity_t got);
            voxel_affinity_t want;
            if (expected_affinities.size() == 0) begin
                $error("result transfer with no voxel pending");
                failures++;
                return;
            end
            want = expected_affinities.pop_front();
            checked++;
            if (got.aff_x !== want.aff_x) begin
                $error("aff_x mismatch: expected %0b, actual %0b", want.aff_x, got.aff_x);
                failures++;
            end
            if (got.aff_y !== want.aff_y) begin
                $error("aff_y mismatch: expected %0b, actual %0b", want.aff_y, got.aff_y);
                failures++;
            end
            if (got.aff_z !== want.aff_z) begin
                $error("aff_z mismatch: expected %0b, actual %0b", want.aff_z, got.aff_z);
                failures++;
            end
            if (got.volume_end !== want.volume_end) begin
                $error("volume_end mismatch: expected %0b, actual %0b",
                       want.volume_end, got.volume_end);
                failures++;
            end
            if (got.history_short !== want.history_short) begin
                $error("history_short mismatch: expected %0b, actual %0b",
                       want.history_short, got.history_short);
                failures++;
            end
            ones[0]    += want.aff_x;
            ones[1]    += want.aff_y;
            ones[2]    += want.aff_z;
            short_seen += want.history_short;
        endfunction
    endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives whole volumes of labels through the affinity graph block under a
// range of sizes and distances, with random gaps on both channels, one long
// output hold-off and a tall column at the largest extent.
// ----------------------------------------------------------------------------
module testbench;

    import agfl_pkg::*;
    import affinity_tb_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1650;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CIDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]          cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [LABEL_W-1:0] s_label;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_aff_x;
    logic                      m_aff_y;
    logic                      m_aff_z;
    logic                      m_volume_end;
    logic                      m_history_short;

    AffinityTracker tracker = new();

    bit               calm;
    bit               hold_off_request;
    bit               hold_armed;
    int               cycle_count;
    int               voxels_sent;
    int               settings_run;
    logic [LABEL_W-1:0] palette [4];
    int               palette_used;
    int               noise_pct;

    affinity_graph_from_labels #(
        .HISTORY_DEPTH (HIST_DEPTH),
        .MAX_EXTENT    (EXTENT_MAX)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_label         (s_label),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_aff_x         (m_aff_x),
        .m_aff_y         (m_aff_y),
        .m_aff_z         (m_aff_z),
        .m_volume_end    (m_volume_end),
        .m_history_short (m_history_short)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // result side: check each transfer, then pick next ready
    initial begin
        int              stall_left;
        voxel_affinity_t got;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                got = {m_aff_x, m_aff_y, m_aff_z, m_volume_end, m_history_short};
                tracker.compare_result(got);
            end
            if (hold_off_request) begin
                stall_left       = HOLD_CYCLES;
                hold_off_request = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 25);
            end
        end
    end

    function automatic void new_palette(input int n, input int noise);
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(1) == 0)
                palette[i] = $urandom_range(1, 6);
            else
                palette[i] = {1'b0, 31'($urandom)};
            if (palette[i] == 0)
                palette[i] = 1;
        end
        palette_used = n;
        noise_pct    = noise;
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label();
        logic [LABEL_W-1:0] lab;
        if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(3))
                0: lab = '0;
                1: lab = {1'b1, 31'($urandom)};
                2: lab = $urandom;
                default: lab = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
        end else begin
            lab = palette[$urandom_range(palette_used - 1)];
        end
        return lab;
    endfunction

    task automatic stream_voxel(input logic [LABEL_W-1:0] lab);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 25)
                gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_label <= lab;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.predict_voxel(lab);
        voxels_sent++;
    endtask

    task automatic wait_drained();
        while (tracker.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure_volume(input int sx, input int sy, input int sz,
                                    input int dx, input int dy, input int dz);
        logic [CIDX_W-1:0] idx [6];
        int                val [6];
        idx = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_DIST_X, REG_DIST_Y, REG_DIST_Z};
        val = '{sx, sy, sz, dx, dy, dz};
        wait_drained();
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= CFG_W'(val[i]);
            @(posedge aclk);
            tracker.write_reg(idx[i], CFG_W'(val[i]));
        end
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // whole volumes only, so every neighbour read hits this volume's labels
    task automatic feed_volumes(input int sx, input int sy, input int sz,
                                input int dx, input int dy, input int dz,
                                input int min_items);
        int vol;
        int ext [3];
        int raw [3];
        raw = '{sx, sy, sz};
        for (int a = 0; a < 3; a++)
            ext[a] = (raw[a] == 0) ? 1 : (raw[a] > EXTENT_MAX ? EXTENT_MAX : raw[a]);
        configure_volume(sx, sy, sz, dx, dy, dz);
        // start the hold-off once the block is configured and voxels keep coming
        if (hold_armed) begin
            hold_off_request = 1'b1;
            hold_armed       = 1'b0;
        end
        vol = ext[0] * ext[1] * ext[2];
        repeat (((min_items + vol - 1) / vol) * vol)
            stream_voxel(pick_label());
        s_valid <= 1'b0;
    endtask

    task automatic run_random_volumes(input int min_items);
        int raw [3];
        int dist_pick [3];
        int r;
        for (int a = 0; a < 3; a++)
            raw[a] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, (a == 0) ? 12 : 6);
        for (int a = 0; a < 3; a++) begin
            r = $urandom_range(99);
            if (r < 15)
                dist_pick[a] = 0;
            else if (r < 25)
                dist_pick[a] = 1023;
            else
                dist_pick[a] = $urandom_range(1, ((raw[a] == 0) ? 1 : raw[a]) + 1);
        end
        new_palette($urandom_range(1, 4), 15);
        feed_volumes(raw[0], raw[1], raw[2], dist_pick[0], dist_pick[1], dist_pick[2],
                     min_items);
    endtask

    initial begin
        logic [LABEL_W-1:0] extreme_labels [5];
        logic [LABEL_W-1:0] self_labels [4];
        logic [LABEL_W-1:0] block_labels [12];
        extreme_labels = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        self_labels    = '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h3};
        block_labels   = '{7, 7, 7, 7, 8, 7, 7, 7, 7, 32'hFFFF_FFF9, 7, 7};
        calm             = 1'b0;
        hold_off_request = 1'b0;
        hold_armed       = 1'b0;
        voxels_sent      = 0;
        settings_run     = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_label   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: single-voxel volumes, nothing reaches back
        foreach (extreme_labels[i])
            stream_voxel(extreme_labels[i]);
        s_valid <= 1'b0;

        // zero distances compare each voxel with itself
        configure_volume(2, 2, 1, 0, 0, 0);
        foreach (self_labels[i])
            stream_voxel(self_labels[i]);
        s_valid <= 1'b0;

        configure_volume(3, 2, 2, 1, 1, 1);
        foreach (block_labels[i])
            stream_voxel(block_labels[i]);
        s_valid <= 1'b0;

        // z offset past the ring on a small volume
        new_palette(2, 15);
        feed_volumes(8, 9, 2, 1, 1, 1023, 144);
        // hold off the result side long enough to back up the input
        hold_armed = 1'b1;
        run_random_volumes(150);
        calm = 1'b1;
        run_random_volumes(150);
        calm = 1'b0;

        // extent 0 and an oversized extent clamped to the maximum
        new_palette(3, 10);
        feed_volumes(1, 0, SIZE_MAX, 0, 1023, 1023, 1);

        while (voxels_sent < RANDOM_ITEMS)
            run_random_volumes($urandom_range(20, 120));

        while (tracker.outstanding() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d voxels over %0d register settings, with self compares",
                 tracker.checked, settings_run + 1);
        $display("affinity ones x/y/z: %0d/%0d/%0d, history_short results: %0d",
                 tracker.ones[0], tracker.ones[1], tracker.ones[2], tracker.short_seen);
        if (tracker.failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### files.f
sv/agfl_pkg.sv
sv/affinity_graph_from_labels.sv
verif/affinity_tb_pkg.sv
verif/testbench.sv
